[rtl/core/ppc_pkg.sv]
package ppc_pkg;

  localparam int unsigned COUNT_W   = 24;
  localparam int unsigned GAIN_W    = 18;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned INTEG_W   = 48;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned APB_W     = 32;

  localparam logic [GAIN_W-1:0] KP_RESET = GAIN_W'(22938);
  localparam logic [GAIN_W-1:0] KI_RESET = GAIN_W'(33);
  localparam logic [GAIN_W-1:0] KD_RESET = GAIN_W'(3277);

  typedef enum logic [1:0] {
    REG_KP = 2'd0,
    REG_KI = 2'd1,
    REG_KD = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

endpackage

[rtl/core/pid_position_controller.sv]
// Position controller, derivative on measurement. Every transaction on the input stream
// gives exactly one transaction on the output stream, in order. With sample_due set the
// block updates the saturating 48-bit integral, forms Kp*error - Kd*(measured - previous
// measured) + Ki*integral with Q2.16 gains, floors it by 2^16 and saturates it to 24 bits;
// with sample_due clear it repeats the last effort and reports updated = 0. One
// transaction is taken per cycle while m_axis_tready keeps the output stream draining; a
// transaction passes five registers (input register, error/integral stage, multiplier
// stage, adder stage, saturating output register) on its way to the output stream.
// Only the integral and previous-count update feeds back on its own registers. Gains
// are written over APB at 0x0 (Kp), 0x4 (Ki) and 0x8 (Kd) and should only change while
// the stream is idle.
module pid_position_controller
  import ppc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [APB_W-1:0]     pwdata,
  output logic [APB_W-1:0]     prdata,
  output logic                 pready,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [2*COUNT_W-1:0] s_axis_tdata,  // [23:0] measured_count, [47:24] target_count
  input  logic                 s_axis_tuser,  // sample_due
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [COUNT_W-1:0]   m_axis_tdata,  // [23:0] drive_effort
  output logic                 m_axis_tuser   // updated
);

  localparam int unsigned DIFF_W = COUNT_W + 1;
  localparam int unsigned PROD_W = DIFF_W + GAIN_W + 1;
  localparam int unsigned HALF_W = INTEG_W / 2;
  localparam int unsigned HI_W   = HALF_W + GAIN_W + 1;
  localparam int unsigned SUM_W  = INTEG_W + GAIN_W + 3;

  localparam logic signed [SUM_W-1:0] EFF_MAX = SUM_W'((64'sd1 <<< (COUNT_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] EFF_MIN = -EFF_MAX - SUM_W'(1);

  function automatic logic signed [COUNT_W-1:0] sat_effort(
    input logic signed [SUM_W-1:0] s
  );
    logic signed [SUM_W-1:0] sh;
    sh = s >>> FRAC_BITS;
    if (sh > EFF_MAX) begin
      sat_effort = EFF_MAX[COUNT_W-1:0];
    end else if (sh < EFF_MIN) begin
      sat_effort = EFF_MIN[COUNT_W-1:0];
    end else begin
      sat_effort = sh[COUNT_W-1:0];
    end
  endfunction

  gains_t gains;

  ppc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .gains_o   (gains)
  );

  // stage valids and per-stage ready (a stage loads when empty or draining)
  logic v0_q, v1_q, v2_q, v3_q, vo_q;
  logic r0, r1, r2, r3, ro;

  assign ro = !vo_q || m_axis_tready;
  assign r3 = !v3_q || ro;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign r0 = !v0_q || r1;
  assign s_axis_tready = r0;

  // stage 0: input register
  logic signed [COUNT_W-1:0] meas0_q, targ0_q;
  logic                      due0_q;

  // stage 1: error, derivative, integral
  logic signed [DIFF_W-1:0]  err1_q, diff1_q;
  logic signed [INTEG_W-1:0] integ1_q;
  logic                      due1_q;

  // controller state
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [COUNT_W-1:0] last_q;

  logic signed [DIFF_W-1:0]  err_d, diff_d;
  logic signed [INTEG_W:0]   isum;

  assign err_d  = $signed({targ0_q[COUNT_W-1], targ0_q}) - $signed({meas0_q[COUNT_W-1], meas0_q});
  assign diff_d = $signed({meas0_q[COUNT_W-1], meas0_q}) - $signed({last_q[COUNT_W-1], last_q});
  assign isum   = $signed({integ_q[INTEG_W-1], integ_q})
                + $signed({{(INTEG_W - DIFF_W + 1){err_d[DIFF_W-1]}}, err_d});

  always_comb begin
    if (isum[INTEG_W] != isum[INTEG_W-1]) begin
      integ_d = {isum[INTEG_W], {(INTEG_W - 1){~isum[INTEG_W]}}};
    end else begin
      integ_d = isum[INTEG_W-1:0];
    end
  end

  // stage 2: partial products, integral term split in two halves
  logic signed [PROD_W-1:0] p2_q, d2_q, ilo2_q;
  logic signed [HI_W-1:0]   ihi2_q;
  logic                     due2_q;

  // stage 3: sum
  logic signed [SUM_W-1:0] sum3_q, sum_d;
  logic                    due3_q;

  assign sum_d = SUM_W'(p2_q) - SUM_W'(d2_q) + (SUM_W'(ihi2_q) <<< HALF_W) + SUM_W'(ilo2_q);

  // output register; its effort field doubles as the held effort
  logic [COUNT_W-1:0] eff_q;
  logic               upd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      vo_q    <= 1'b0;
      integ_q <= '0;
      last_q  <= '0;
      eff_q   <= '0;
    end else begin
      if (r0) v0_q <= s_axis_tvalid;
      if (r1) v1_q <= v0_q;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (ro) vo_q <= v3_q;
      if (r1 && v0_q && due0_q) begin
        integ_q <= integ_d;
        last_q  <= meas0_q;
      end
      if (ro && v3_q && due3_q) begin
        eff_q <= sat_effort(sum3_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r0 && s_axis_tvalid) begin
      meas0_q <= s_axis_tdata[COUNT_W-1:0];
      targ0_q <= s_axis_tdata[2*COUNT_W-1:COUNT_W];
      due0_q  <= s_axis_tuser;
    end
    if (r1 && v0_q) begin
      err1_q   <= err_d;
      diff1_q  <= diff_d;
      integ1_q <= due0_q ? integ_d : integ_q;
      due1_q   <= due0_q;
    end
    if (r2 && v1_q) begin
      p2_q   <= PROD_W'($signed({1'b0, gains.kp})) * PROD_W'(err1_q);
      d2_q   <= PROD_W'($signed({1'b0, gains.kd})) * PROD_W'(diff1_q);
      ilo2_q <= PROD_W'($signed({1'b0, gains.ki}))
              * PROD_W'($signed({1'b0, integ1_q[HALF_W-1:0]}));
      ihi2_q <= HI_W'($signed({1'b0, gains.ki}))
              * HI_W'($signed(integ1_q[INTEG_W-1:HALF_W]));
      due2_q <= due1_q;
    end
    if (r3 && v2_q) begin
      sum3_q <= sum_d;
      due3_q <= due2_q;
    end
    if (ro && v3_q) begin
      upd_q <= due3_q;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = eff_q;
  assign m_axis_tuser  = upd_q;

endmodule

[rtl/core/ppc_cfg_regs.sv]
module ppc_cfg_regs
  import ppc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [APB_W-1:0]  pwdata_i,
  output logic [APB_W-1:0]  prdata_o,
  output logic              pready_o,
  output gains_t            gains_o
);

  gains_t     gains_q, gains_d;
  logic       wr_en;
  reg_idx_e   idx;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign idx      = reg_idx_e'(paddr_i[ADDR_W-1:2]);

  always_comb begin
    gains_d = gains_q;
    if (wr_en) begin
      unique case (idx)
        REG_KP:  gains_d.kp = pwdata_i[GAIN_W-1:0];
        REG_KI:  gains_d.ki = pwdata_i[GAIN_W-1:0];
        REG_KD:  gains_d.kd = pwdata_i[GAIN_W-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KP:  prdata_o = APB_W'(gains_q.kp);
      REG_KI:  prdata_o = APB_W'(gains_q.ki);
      REG_KD:  prdata_o = APB_W'(gains_q.kd);
      default: prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.kp <= KP_RESET;
      gains_q.ki <= KI_RESET;
      gains_q.kd <= KD_RESET;
    end else begin
      gains_q <= gains_d;
    end
  end

  assign gains_o = gains_q;

endmodule
